@@ rtl/core/nmea_gga_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA GGA parser package
// Shared types, codes and constants for the GGA sentence parser.
// ----------------------------------------------------------------------------
package nmea_gga_pkg;

    localparam int MaxFieldLen = 16;
    localparam int FlenW       = $clog2(MaxFieldLen + 1);
    localparam int QueueDepth  = 2;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusNotGga   = 2'd1;
    localparam logic [1:0] StatusOverflow = 2'd2;

    localparam logic [3:0] FldUtc  = 4'd0;
    localparam logic [3:0] FldLat  = 4'd1;
    localparam logic [3:0] FldNs   = 4'd2;
    localparam logic [3:0] FldLon  = 4'd3;
    localparam logic [3:0] FldEw   = 4'd4;
    localparam logic [3:0] FldFix  = 4'd5;
    localparam logic [3:0] FldSats = 4'd6;
    localparam logic [3:0] FldAlt  = 4'd8;

    typedef enum logic [1:0] {
        OP_COMMIT = 2'd0,
        OP_EMIT   = 2'd1
    } t_op;

    // one classified field handed from front to back
    typedef struct packed {
        t_op         op;
        logic [1:0]  status;
        logic        valid_fld;
        logic [3:0]  index;
        logic        neg;
        logic [31:0] whole;
        logic [31:0] frac;
        logic [7:0]  first;
    } t_cmd;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        up_case = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    endfunction

    function automatic logic [31:0] mac10(input logic [31:0] a, input logic [3:0] d);
        logic [35:0] v;
        v = {4'd0, a} * 36'd10 + {32'd0, d};
        mac10 = (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/nmea_gga_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA GGA front end
// Matches the header, splits fields and accumulates number digits per byte.
// ----------------------------------------------------------------------------
module nmea_gga_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [7:0]          i_char_byte,
    input  wire logic                i_cmd_full,
    output logic                     o_full,
    output logic                     o_cmd_push,
    output nmea_gga_pkg::t_cmd       o_cmd
);
    import nmea_gga_pkg::*;

    logic [2:0]       r_hpos, n_hpos;
    logic             r_hok, n_hok;
    logic [3:0]       r_fidx, n_fidx;
    logic [FlenW-1:0] r_flen, n_flen;
    logic             r_infrac, n_infrac;
    logic             r_neg, n_neg;
    logic [31:0]      r_whole, n_whole;
    logic [31:0]      r_frac, n_frac;
    logic [7:0]       r_first, n_first;
    logic             r_ovf, n_ovf;
    logic             r_ndone, n_ndone;
    logic [7:0]       hdr_ch;
    logic [7:0]       c;
    logic             acc;

    assign o_full = i_cmd_full;
    assign acc    = i_push && !i_cmd_full;
    assign c      = i_char_byte;

    always_comb begin
        unique case (r_hpos)
            3'd1, 3'd3, 3'd4: hdr_ch = 8'h47;
            3'd2:             hdr_ch = 8'h50;
            default:          hdr_ch = 8'h41;
        endcase
    end

    always_comb begin
        n_hpos = r_hpos; n_hok = r_hok; n_fidx = r_fidx; n_flen = r_flen;
        n_infrac = r_infrac; n_neg = r_neg; n_whole = r_whole; n_frac = r_frac;
        n_first = r_first; n_ovf = r_ovf; n_ndone = r_ndone;
        o_cmd_push = 1'b0;
        o_cmd = '{op: OP_COMMIT, status: StatusOk, valid_fld: 1'b0, index: r_fidx,
                  neg: r_neg, whole: r_whole, frac: r_frac, first: r_first};
        if (acc) begin
            priority if (c == 8'h24) begin
                n_hpos = 3'd1; n_hok = 1'b0; n_fidx = '0; n_ovf = 1'b0;
                n_flen = '0; n_infrac = 1'b0; n_neg = 1'b0; n_whole = '0;
                n_frac = '0; n_first = '0; n_ndone = 1'b0;
            end else if (!r_hok) begin
                if (r_hpos >= 3'd1 && r_hpos <= 3'd5) begin
                    if (up_case(c) == hdr_ch) begin
                        n_hpos = r_hpos + 3'd1;
                    end else begin
                        o_cmd_push = 1'b1;
                        o_cmd.op = OP_EMIT;
                        o_cmd.status = StatusNotGga;
                        n_hpos = '0; n_fidx = '0; n_flen = '0; n_infrac = 1'b0;
                        n_neg = 1'b0; n_whole = '0; n_frac = '0; n_first = '0;
                        n_ndone = 1'b0;
                    end
                end else if (r_hpos != 3'd0) begin
                    n_hpos = 3'd7; n_hok = 1'b1; n_fidx = '0; n_flen = '0;
                    n_infrac = 1'b0; n_neg = 1'b0; n_whole = '0; n_frac = '0;
                    n_first = '0; n_ndone = 1'b0;
                end
            end else if (c == 8'h2c) begin
                o_cmd_push = 1'b1;
                o_cmd.valid_fld = (r_flen != '0) && (r_flen < FlenW'(MaxFieldLen));
                n_ovf = r_ovf || (r_flen >= FlenW'(MaxFieldLen));
                o_cmd.status = n_ovf ? StatusOverflow : StatusOk;
                o_cmd.op = (r_fidx >= FldAlt) ? OP_EMIT : OP_COMMIT;
                n_flen = '0; n_infrac = 1'b0; n_neg = 1'b0; n_whole = '0;
                n_frac = '0; n_first = '0; n_ndone = 1'b0;
                if (r_fidx >= FldAlt) begin
                    n_hpos = '0; n_hok = 1'b0; n_fidx = '0;
                end else begin
                    n_fidx = r_fidx + 4'd1;
                end
            end else begin
                if (r_flen == '0) n_first = c;
                if (!r_ndone) begin
                    priority if (r_flen == '0 && (c == 8'h2b || c == 8'h2d)) begin
                        n_neg = (c == 8'h2d);
                    end else if (c >= 8'h30 && c <= 8'h39) begin
                        if (!r_infrac) begin
                            n_whole = mac10(r_whole, c[3:0]);
                        end else begin
                            n_frac = mac10(r_frac, c[3:0]);
                            if (r_fidx == FldAlt) n_ndone = 1'b1;
                        end
                    end else if (c == 8'h2e && !r_infrac) begin
                        n_infrac = 1'b1;
                    end else begin
                        n_ndone = 1'b1;
                    end
                end
                if (r_flen < FlenW'(MaxFieldLen)) n_flen = r_flen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos <= '0; r_hok <= 1'b0; r_fidx <= '0; r_flen <= '0;
            r_infrac <= 1'b0; r_neg <= 1'b0; r_whole <= '0; r_frac <= '0;
            r_first <= '0; r_ovf <= 1'b0; r_ndone <= 1'b0;
        end else begin
            r_hpos <= n_hpos; r_hok <= n_hok; r_fidx <= n_fidx; r_flen <= n_flen;
            r_infrac <= n_infrac; r_neg <= n_neg; r_whole <= n_whole;
            r_frac <= n_frac; r_first <= n_first; r_ovf <= n_ovf;
            r_ndone <= n_ndone;
        end
    end

`ifndef NO_ASSERTIONS
    a_flen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flen <= FlenW'(MaxFieldLen)) else $error("field length beyond cap");
    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hok |-> r_hpos == 3'd7) else $error("body without header");
    a_fidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fidx <= FldAlt) else $error("field index out of range");
`endif
endmodule
`default_nettype wire

@@ rtl/core/nmea_gga_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA GGA command queue
// Short FIFO between the front end and the field back end.
// ----------------------------------------------------------------------------
module nmea_gga_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  nmea_gga_pkg::t_cmd       i_cmd,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output nmea_gga_pkg::t_cmd       o_cmd
);
    import nmea_gga_pkg::*;

    localparam int AW = $clog2(QueueDepth);

    t_cmd          r_mem [QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == (AW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(QueueDepth - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(QueueDepth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QueueDepth)) else $error("queue count overrun");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (AW+1)'(QueueDepth)) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");
    a_gone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !i_push) |=> o_empty) else $error("phantom entry");
`endif
endmodule
`default_nettype wire

@@ rtl/core/nmea_gga_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA GGA back end
// Scales and commits field values to the held record and emits results.
// ----------------------------------------------------------------------------
module nmea_gga_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_empty,
    input  nmea_gga_pkg::t_cmd       i_cmd,
    output logic                     o_cmd_pop,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [1:0]               o_status,
    output logic [19:0]              o_utc_hhmmss,
    output logic [31:0]              o_lat_scaled,
    output logic                     o_north_flag,
    output logic [31:0]              o_lon_scaled,
    output logic                     o_east_flag,
    output logic [7:0]               o_fix_quality,
    output logic [7:0]               o_sats_used,
    output logic signed [31:0]       o_alt_tenths
);
    import nmea_gga_pkg::*;

    // stage 1: scaled products
    logic        r_s1_v;
    t_cmd        r_s1;
    logic [45:0] r_prod;
    logic [35:0] r_alt;
    logic        s1_adv;

    logic [19:0] r_utc;
    logic [31:0] r_lat, r_lon, r_alt_h;
    logic        r_n, r_e;
    logic [7:0]  r_fix, r_sats;

    logic        r_ov;
    logic [1:0]  r_ost;
    logic [19:0] r_outc;
    logic [31:0] r_olat, r_olon, r_oalt;
    logic        r_on, r_oe;
    logic [7:0]  r_ofix, r_osats;

    logic [46:0] sc;
    logic [31:0] scv, altv;
    logic [7:0]  cap8;
    logic [19:0] cap20;
    logic        emit_ok;

    // emitting needs the output slot free; commits never stall
    assign emit_ok  = !r_ov || i_pop;
    assign s1_adv   = r_s1_v && (r_s1.op != OP_EMIT || emit_ok);
    assign o_cmd_pop = !i_cmd_empty && (!r_s1_v || s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (!r_s1_v || s1_adv) begin
            r_s1_v <= o_cmd_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1   <= i_cmd;
            r_prod <= {14'd0, i_cmd.whole} * 46'd10000;
            r_alt  <= {4'd0, i_cmd.whole} * 36'd10;
        end
    end

    always_comb begin
        sc    = {1'b0, r_prod} + {15'd0, r_s1.frac};
        scv   = r_s1.neg ? '0 : (sc > 47'hFFFF_FFFF ? 32'hFFFF_FFFF : sc[31:0]);
        cap8  = r_s1.neg ? '0 : (r_s1.whole > 32'd255 ? 8'd255 : r_s1.whole[7:0]);
        cap20 = r_s1.neg ? '0 :
                (r_s1.whole > 32'd999999 ? 20'd999999 : r_s1.whole[19:0]);
        begin : alt_blk
            logic [36:0] v;
            v = {1'b0, r_alt} + {5'd0, r_s1.frac};
            if (r_s1.neg) begin
                altv = (v > 37'h8000_0000) ? 32'h8000_0000 : 32'd0 - v[31:0];
            end else begin
                altv = (v > 37'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utc <= '0; r_lat <= '0; r_lon <= '0; r_alt_h <= '0;
            r_n <= 1'b0; r_e <= 1'b0; r_fix <= '0; r_sats <= '0;
        end else if (s1_adv && r_s1.valid_fld) begin
            unique case (r_s1.index)
                FldUtc:  r_utc   <= cap20;
                FldLat:  r_lat   <= scv;
                FldNs:   r_n     <= (up_case(r_s1.first) == 8'h4e);
                FldLon:  r_lon   <= scv;
                FldEw:   r_e     <= (up_case(r_s1.first) == 8'h45);
                FldFix:  r_fix   <= cap8;
                FldSats: r_sats  <= cap8;
                FldAlt:  r_alt_h <= altv;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_adv && r_s1.op == OP_EMIT) begin
            r_ov <= 1'b1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.op == OP_EMIT) begin
            r_ost   <= r_s1.status;
            r_outc  <= r_utc;
            r_olat  <= r_lat;
            r_on    <= r_n;
            r_olon  <= r_lon;
            r_oe    <= r_e;
            r_ofix  <= r_fix;
            r_osats <= r_sats;
            r_oalt  <= (r_s1.valid_fld && r_s1.index == FldAlt) ? altv : r_alt_h;
        end
    end

    assign o_empty       = !r_ov;
    assign o_status      = r_ost;
    assign o_utc_hhmmss  = r_outc;
    assign o_lat_scaled  = r_olat;
    assign o_north_flag  = r_on;
    assign o_lon_scaled  = r_olon;
    assign o_east_flag   = r_oe;
    assign o_fix_quality = r_ofix;
    assign o_sats_used   = r_osats;
    assign o_alt_tenths  = r_oalt;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_pop) |=> r_ov && $stable(r_oalt) && $stable(r_ost))
        else $error("result changed while waiting");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_ost != 2'd3) else $error("bad status");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_adv) |=> r_s1_v) else $error("stage dropped");
`endif
endmodule
`default_nettype wire

@@ rtl/core/nmea_gga_sentence_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA GGA sentence parser
// Byte-serial GGA decoder with queue-style input and result channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_char_byte with i_push; a byte is taken when
//   i_push is high and o_full is low. One byte per cycle is sustained until o_full rises.
//   Result channel: a result is presented while o_empty is low and leaves
//   on a cycle with i_pop high. One result per sentence ('$GPGGA' closed
//   by the comma after altitude) or per header mismatch.
//   The result of a sentence passes the command queue write, the scaling
//   stage and the output register in turn before o_empty falls.
//   The scaling multiply of the back end sets the stage boundaries;
//   throughput is one transaction per cycle unless a result waits on i_pop.
//   When the receiver stalls, the output register, the scaling stage and
//   a two-entry command queue fill before o_full rises; field commits
//   continue to flow while a result waits.
//   Reset (synchronous, i_rst_n low) returns the parser to idle outside a
//   sentence and clears all held field values to zero.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic [7:0]          i_char_byte,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [1:0]               o_status,
    output logic [19:0]              o_utc_hhmmss,
    output logic [31:0]              o_lat_scaled,
    output logic                     o_north_flag,
    output logic [31:0]              o_lon_scaled,
    output logic                     o_east_flag,
    output logic [7:0]               o_fix_quality,
    output logic [7:0]               o_sats_used,
    output logic signed [31:0]       o_alt_tenths
);
    import nmea_gga_pkg::*;

    t_cmd f_cmd, q_cmd;
    logic f_push, q_full, q_empty, q_pop;

    nmea_gga_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_char_byte,
        .i_cmd_full(q_full), .o_full, .o_cmd_push(f_push), .o_cmd(f_cmd)
    );

    nmea_gga_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_push), .i_cmd(f_cmd), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    nmea_gga_back u_back (
        .i_clk, .i_rst_n, .i_cmd_empty(q_empty), .i_cmd(q_cmd), .o_cmd_pop(q_pop),
        .i_pop, .o_empty, .o_status, .o_utc_hhmmss, .o_lat_scaled, .o_north_flag,
        .o_lon_scaled, .o_east_flag, .o_fix_quality, .o_sats_used, .o_alt_tenths
    );
endmodule
`default_nettype wire
